FILE: hdl/trz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types and constants of the triangle rasteriser with depth buffer.
// ----------------------------------------------------------------------------
package trz_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(PIXEL_COUNT);

  // Edge function width and width of the weighted depth sum.
  localparam int L_W = 38;
  localparam int N_W = L_W + 18;

  localparam logic [12:0] WRITE_LIMIT = 13'd4096;
  localparam logic [15:0] FAR_DEPTH   = 16'hFFFF;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic REG_CLEAR_COLOR = 1'b0;
  localparam logic REG_WIREFRAME   = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic [15:0]        v0_depth;
    logic [15:0]        v1_depth;
    logic [15:0]        v2_depth;
    logic [31:0]        tri_color;
    logic [11:0]        read_index;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [15:0] pixel_depth;
    logic [12:0] pixels_written;
    logic        degenerate;
  } result_t;

  typedef struct packed {
    logic              wr_color;
    logic              wr_depth;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       color;
    logic [15:0]       depth;
  } mem_wr_t;

  typedef struct packed {
    logic               active;
    logic               last;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } line_pt_t;

endpackage

FILE: hdl/trz_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_mem
// Colour and depth frame stores, one write port and one registered read port.
// ----------------------------------------------------------------------------
module trz_mem (
  input  logic                        clk,
  input  trz_pkg::mem_wr_t            wr,
  input  logic                        rd_en,
  input  logic [trz_pkg::ADDR_W-1:0]  rd_addr,
  output logic [31:0]                 rd_color,
  output logic [15:0]                 rd_depth
);
  import trz_pkg::*;

  logic [31:0] color_mem [PIXEL_COUNT];
  logic [15:0] depth_mem [PIXEL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.wr_color) begin
      color_mem[wr.addr] <= wr.color;
    end
    if (wr.wr_depth) begin
      depth_mem[wr.addr] <= wr.depth;
    end
    if (rd_en) begin
      rd_color <= color_mem[rd_addr];
      rd_depth <= depth_mem[rd_addr];
    end
  end

endmodule

FILE: hdl/trz_zunit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_zunit
// Serial depth interpolator: bit-serial weighted sum, then restoring divide
// by the triangle area.
// ----------------------------------------------------------------------------
module trz_zunit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [trz_pkg::L_W-1:0]  l0,
  input  logic signed [trz_pkg::L_W-1:0]  l1,
  input  logic signed [trz_pkg::L_W-1:0]  l2,
  input  logic signed [trz_pkg::L_W-1:0]  area,
  input  logic [15:0]                     d0,
  input  logic [15:0]                     d1,
  input  logic [15:0]                     d2,
  output logic                            done,
  output logic [15:0]                     z
);
  import trz_pkg::*;

  typedef enum logic [1:0] {Z_IDLE, Z_MUL, Z_DIV} zstate_t;

  zstate_t        zs;
  logic [3:0]     cnt;
  logic [L_W-1:0] m0, m1, m2, dv;
  logic [15:0]    dr0, dr1, dr2;
  logic [N_W-1:0] acc, dsh, addend;
  logic           neg;

  assign neg = area[L_W-1];

  always_comb begin
    addend = '0;
    if (dr0[cnt]) addend = addend + N_W'(m0);
    if (dr1[cnt]) addend = addend + N_W'(m1);
    if (dr2[cnt]) addend = addend + N_W'(m2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zs   <= Z_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (zs)
        Z_IDLE: begin
          if (start) begin
            m0  <= neg ? L_W'(-l0) : L_W'(l0);
            m1  <= neg ? L_W'(-l1) : L_W'(l1);
            m2  <= neg ? L_W'(-l2) : L_W'(l2);
            dv  <= neg ? L_W'(-area) : L_W'(area);
            dr0 <= d0;
            dr1 <= d1;
            dr2 <= d2;
            acc <= '0;
            cnt <= 4'd15;
            zs  <= Z_MUL;
          end
        end
        Z_MUL: begin
          acc <= (acc << 1) + addend;
          if (cnt == 4'd0) begin
            cnt <= 4'd15;
            dsh <= N_W'(dv) << 15;
            zs  <= Z_DIV;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        Z_DIV: begin
          if (acc >= dsh) begin
            acc <= acc - dsh;
            z   <= {z[14:0], 1'b1};
          end else begin
            z   <= {z[14:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (cnt == 4'd0) begin
            done <= 1'b1;
            zs   <= Z_IDLE;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        default: zs <= Z_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/trz_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trz_line
// Bresenham line stepper, one point per cycle from start to end point.
// ----------------------------------------------------------------------------
module trz_line (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] xs,
  input  logic signed [15:0] ys,
  input  logic signed [15:0] xe,
  input  logic signed [15:0] ye,
  output trz_pkg::line_pt_t  pt
);
  import trz_pkg::*;

  logic               active;
  logic signed [15:0] xa, ya, xb, yb;
  logic signed [17:0] dx, dy;
  logic signed [19:0] err, err_next;
  logic signed [20:0] e2;
  logic               sx, sy, xstep, ystep, last;
  logic signed [17:0] ldx, ldy;

  assign ldx  = {{2{xe[15]}}, xe} - {{2{xs[15]}}, xs};
  assign ldy  = {{2{ye[15]}}, ye} - {{2{ys[15]}}, ys};
  assign last = (xa == xb) && (ya == yb);
  assign e2   = {err, 1'b0};
  assign xstep = e2 >= 21'(dy);
  assign ystep = e2 <= 21'(dx);

  always_comb begin
    err_next = err;
    if (xstep) err_next = err_next + 20'(dy);
    if (ystep) err_next = err_next + 20'(dx);
  end

  assign pt = '{active: active, last: last, x: xa, y: ya};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
      xa  <= xs;
      ya  <= ys;
      xb  <= xe;
      yb  <= ye;
      dx  <= ldx[17] ? -ldx : ldx;
      dy  <= ldy[17] ? ldy : -ldy;
      sx  <= ~ldx[17] && (ldx != 18'sd0);
      sy  <= ~ldy[17] && (ldy != 18'sd0);
      err <= 20'(ldx[17] ? -ldx : ldx) + 20'(ldy[17] ? ldy : -ldy);
    end else if (active) begin
      if (last) begin
        active <= 1'b0;
      end else begin
        err <= err_next;
        if (xstep) xa <= sx ? xa + 16'sd1 : xa - 16'sd1;
        if (ystep) ya <= sy ? ya + 16'sd1 : ya - 16'sd1;
      end
    end
  end

endmodule

FILE: hdl/triangle_zbuffer_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_zbuffer_raster
// Edge function triangle rasteriser with colour and depth frame stores.
//
//   channel  direction  signals
//   cmd      in         cmd_valid, cmd_stall, cmd
//   result   out        result_valid, result_stall, result
//   cfg      in         cfg_we, cfg_index, cfg_data
//
// A filled draw computes its edge setup on one shared multiplier, then tests
// each box pixel against the triangle; a pixel inside it waits for the serial
// depth interpolator. A wireframe draw writes each on-screen line point.
// After reset a clearing pass over all PIXEL_COUNT pixels holds cmd_stall high.
// A finished result waits in the output register while the next command runs.
// ----------------------------------------------------------------------------
module triangle_zbuffer_raster (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  trz_pkg::cmd_t     cmd,
  output logic              result_valid,
  input  logic              result_stall,
  output trz_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import trz_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_READ, S_RDWAIT, S_SETUP, S_FCHK, S_PTEST, S_PZ,
    S_LSTART, S_LINE, S_FINISH
  } state_t;

  localparam logic signed [17:0] XMAX = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] YMAX = 18'(SCREEN_HEIGHT - 1);

  state_t             state;
  logic               init_pass, wireframe_mode, degen;
  logic [ADDR_W-1:0]  ccnt;
  logic [31:0]        fill_color, clear_color, res_color;
  logic [15:0]        res_depth;
  logic [12:0]        wcnt;
  cmd_t               c;
  logic [3:0]         sc;
  logic [1:0]         line_idx;
  logic signed [35:0] prod;
  logic signed [L_W-1:0] area, er0, er1, er2, ec0, ec1, ec2;
  logic signed [17:0] px, py;

  logic signed [17:0] x0e, y0e, x1e, y1e, x2e, y2e;
  logic signed [17:0] a0, b0, a1, b1, a2, b2;
  logic signed [17:0] min_x, max_x, min_y, max_y, lo_x, hi_x, lo_y, hi_y;
  logic signed [17:0] mul_a, mul_b;
  logic signed [L_W-1:0] prodx, tgt_old, acc_val;
  logic [3:0]         step;
  logic               box_ok, in_tri, at_xend, at_end, rd_in_range, z_near, on_screen;
  logic [ADDR_W-1:0]  pix_addr, line_addr, rd_addr;
  logic               rd_en, z_done, line_start;
  logic [1:0]         sel;
  logic signed [15:0] lxs, lys, lxe, lye;
  logic [15:0]        z, rd_depth;
  logic [31:0]        rd_color;
  mem_wr_t            mem_wr;
  line_pt_t           pt;

  assign x0e = {{2{c.v0_x[15]}}, c.v0_x};
  assign y0e = {{2{c.v0_y[15]}}, c.v0_y};
  assign x1e = {{2{c.v1_x[15]}}, c.v1_x};
  assign y1e = {{2{c.v1_y[15]}}, c.v1_y};
  assign x2e = {{2{c.v2_x[15]}}, c.v2_x};
  assign y2e = {{2{c.v2_y[15]}}, c.v2_y};
  assign a0 = x2e - x1e;
  assign b0 = y2e - y1e;
  assign a1 = x0e - x2e;
  assign b1 = y0e - y2e;
  assign a2 = x1e - x0e;
  assign b2 = y1e - y0e;

  always_comb begin
    min_x = (x0e < x1e) ? x0e : x1e;
    if (x2e < min_x) min_x = x2e;
    max_x = (x0e > x1e) ? x0e : x1e;
    if (x2e > max_x) max_x = x2e;
    min_y = (y0e < y1e) ? y0e : y1e;
    if (y2e < min_y) min_y = y2e;
    max_y = (y0e > y1e) ? y0e : y1e;
    if (y2e > max_y) max_y = y2e;
    lo_x = min_x[17] ? 18'sd0 : min_x;
    lo_y = min_y[17] ? 18'sd0 : min_y;
    hi_x = (max_x > XMAX) ? XMAX : max_x;
    hi_y = (max_y > YMAX) ? YMAX : max_y;
  end

  assign box_ok = (lo_x <= hi_x) && (lo_y <= hi_y);

  always_comb begin
    case (sc[2:0])
      3'd0:    begin mul_a = a1; mul_b = b2;         end
      3'd1:    begin mul_a = a2; mul_b = b1;         end
      3'd2:    begin mul_a = a0; mul_b = lo_y - y1e; end
      3'd3:    begin mul_a = b0; mul_b = lo_x - x1e; end
      3'd4:    begin mul_a = a1; mul_b = lo_y - y2e; end
      3'd5:    begin mul_a = b1; mul_b = lo_x - x2e; end
      3'd6:    begin mul_a = a2; mul_b = lo_y - y0e; end
      default: begin mul_a = b2; mul_b = lo_x - x0e; end
    endcase
  end

  assign step  = sc - 4'd1;
  assign prodx = {{(L_W-36){prod[35]}}, prod};

  always_comb begin
    case (step[2:1])
      2'd0:    tgt_old = area;
      2'd1:    tgt_old = er0;
      2'd2:    tgt_old = er1;
      default: tgt_old = er2;
    endcase
    acc_val = step[0] ? tgt_old - prodx : prodx;
  end

  always_comb begin
    if (area[L_W-1]) begin
      in_tri = (ec0[L_W-1] || ec0 == '0) && (ec1[L_W-1] || ec1 == '0) &&
               (ec2[L_W-1] || ec2 == '0);
    end else begin
      in_tri = !ec0[L_W-1] && !ec1[L_W-1] && !ec2[L_W-1];
    end
  end

  assign at_xend     = (px == hi_x);
  assign at_end      = at_xend && (py == hi_y);
  assign pix_addr    = ADDR_W'(py) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(px);
  assign rd_in_range = 32'(c.read_index) < PIXEL_COUNT;
  assign rd_en       = (state == S_PTEST && in_tri) || (state == S_READ && rd_in_range);
  assign rd_addr     = (state == S_READ) ? ADDR_W'(c.read_index) : pix_addr;
  assign z_near      = z_done && (z < rd_depth);

  assign on_screen = pt.active && !pt.x[15] && (pt.x < SCREEN_WIDTH) &&
                     !pt.y[15] && (pt.y < SCREEN_HEIGHT);
  assign line_addr = ADDR_W'(pt.y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pt.x);
  assign line_start = (state == S_LSTART) ||
                      (state == S_LINE && pt.last && line_idx != 2'd2);
  assign sel = (state == S_LSTART) ? 2'd0 : line_idx + 2'd1;

  always_comb begin
    case (sel)
      2'd0:    begin lxs = c.v0_x; lys = c.v0_y; lxe = c.v1_x; lye = c.v1_y; end
      2'd1:    begin lxs = c.v1_x; lys = c.v1_y; lxe = c.v2_x; lye = c.v2_y; end
      default: begin lxs = c.v2_x; lys = c.v2_y; lxe = c.v0_x; lye = c.v0_y; end
    endcase
  end

  always_comb begin
    mem_wr = '0;
    case (state)
      S_CLEAR: begin
        mem_wr = '{wr_color: 1'b1, wr_depth: 1'b1, addr: ccnt,
                   color: fill_color, depth: FAR_DEPTH};
      end
      S_PZ: begin
        mem_wr = '{wr_color: z_near, wr_depth: z_near, addr: pix_addr,
                   color: c.tri_color, depth: z};
      end
      S_LINE: begin
        mem_wr = '{wr_color: on_screen, wr_depth: 1'b0, addr: line_addr,
                   color: c.tri_color, depth: FAR_DEPTH};
      end
      default: mem_wr = '0;
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

  trz_mem u_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_color (rd_color),
    .rd_depth (rd_depth)
  );

  trz_zunit u_zunit (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_PTEST && in_tri),
    .l0    (ec0),
    .l1    (ec1),
    .l2    (ec2),
    .area  (area),
    .d0    (c.v0_depth),
    .d1    (c.v1_depth),
    .d2    (c.v2_depth),
    .done  (z_done),
    .z     (z)
  );

  trz_line u_line (
    .clk   (clk),
    .rst   (rst),
    .start (line_start),
    .xs    (lxs),
    .ys    (lys),
    .xe    (lxe),
    .ye    (lye),
    .pt    (pt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      init_pass      <= 1'b1;
      ccnt           <= '0;
      fill_color     <= '0;
      clear_color    <= '0;
      wireframe_mode <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLEAR_COLOR: clear_color    <= cfg_data;
          REG_WIREFRAME:   wireframe_mode <= cfg_data[0];
          default:         clear_color    <= clear_color;
        endcase
      end
      if (!result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      if (state == S_PTEST || (state == S_PZ && z_done)) begin
        if (state == S_PZ || !in_tri) begin
          if (at_xend) begin
            px  <= lo_x;
            py  <= py + 18'sd1;
            er0 <= er0 + L_W'(a0);
            er1 <= er1 + L_W'(a1);
            er2 <= er2 + L_W'(a2);
            ec0 <= er0 + L_W'(a0);
            ec1 <= er1 + L_W'(a1);
            ec2 <= er2 + L_W'(a2);
          end else begin
            px  <= px + 18'sd1;
            ec0 <= ec0 - L_W'(b0);
            ec1 <= ec1 - L_W'(b1);
            ec2 <= ec2 - L_W'(b2);
          end
        end
      end

      if ((state == S_PZ && z_near) || (state == S_LINE && on_screen)) begin
        if (wcnt != WRITE_LIMIT) wcnt <= wcnt + 13'd1;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            c         <= cmd;
            wcnt      <= '0;
            degen     <= 1'b0;
            res_color <= '0;
            res_depth <= '0;
            sc        <= '0;
            line_idx  <= '0;
            ccnt      <= '0;
            fill_color <= clear_color;
            case (cmd.op)
              OP_DRAW:  state <= wireframe_mode ? S_LSTART : S_SETUP;
              OP_CLEAR: state <= S_CLEAR;
              OP_READ:  state <= S_READ;
              default:  state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          ccnt <= ccnt + 1'b1;
          if (ccnt == ADDR_W'(PIXEL_COUNT - 1)) begin
            init_pass <= 1'b0;
            state     <= init_pass ? S_IDLE : S_FINISH;
          end
        end
        S_READ: state <= S_RDWAIT;
        S_RDWAIT: begin
          if (rd_in_range) begin
            res_color <= rd_color;
            res_depth <= rd_depth;
          end
          state <= S_FINISH;
        end
        S_SETUP: begin
          if (sc != 4'd8) prod <= mul_a * mul_b;
          if (sc != 4'd0) begin
            case (step[2:1])
              2'd0:    area <= acc_val;
              2'd1:    er0  <= acc_val;
              2'd2:    er1  <= acc_val;
              default: er2  <= acc_val;
            endcase
          end
          if (sc == 4'd8) state <= S_FCHK;
          sc <= sc + 4'd1;
        end
        S_FCHK: begin
          if (area == '0) begin
            degen <= 1'b1;
            state <= S_FINISH;
          end else if (!box_ok) begin
            state <= S_FINISH;
          end else begin
            ec0   <= er0;
            ec1   <= er1;
            ec2   <= er2;
            px    <= lo_x;
            py    <= lo_y;
            state <= S_PTEST;
          end
        end
        S_PTEST: begin
          if (in_tri) begin
            state <= S_PZ;
          end else if (at_end) begin
            state <= S_FINISH;
          end
        end
        S_PZ: begin
          if (z_done) state <= at_end ? S_FINISH : S_PTEST;
        end
        S_LSTART: state <= S_LINE;
        S_LINE: begin
          if (pt.last) begin
            if (line_idx == 2'd2) state <= S_FINISH;
            else line_idx <= line_idx + 2'd1;
          end
        end
        S_FINISH: begin
          if (!result_valid || !result_stall) begin
            result <= '{pixel_color: res_color, pixel_depth: res_depth,
                        pixels_written: wcnt, degenerate: degen};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.pixels_written <= WRITE_LIMIT)
    else $error("write count above limit");

  a_degen_no_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> result.pixels_written == 13'd0)
    else $error("degenerate draw reported writes");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_wr.wr_color && !mem_wr.wr_depth)
    else $error("store written while idle");

  a_zdone_state: assert property (@(posedge clk) disable iff (rst)
    z_done |-> state == S_PZ)
    else $error("depth result outside pixel wait");

endmodule
